>>> rtl/core/fcr_pkg.sv
// ----------------------------------------------------------------------------
// Framed command receiver package
// Shared constants, status codes and the reply record passed between the
// frame receiver and the reply transmitter.
// ----------------------------------------------------------------------------
package fcr_pkg;

   // Number of frame positions that are kept in the frame store.
   localparam int FRAME_BYTES = 10;
   localparam int FRAME_IDX_W = $clog2(FRAME_BYTES);

   // Frame position counter saturates at this value.
   localparam logic [4:0] POS_MAX = 5'd31;

   // Framing bytes.
   localparam logic [7:0] HEAD_BYTE  = 8'h68;
   localparam logic [7:0] TAIL_BYTE  = 8'h23;
   localparam logic [7:0] REPLY_KIND = 8'h01;

   // Reply status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_TAIL = 2'd1;
   localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;

   // Index of the final byte of the seven-byte reply.
   localparam logic [2:0] REPLY_LAST_IDX = 3'd6;

   // Everything the transmitter needs to build one reply.
   typedef struct packed {
      logic [7:0]  address;
      logic [7:0]  command;
      logic [1:0]  status;
      logic [31:0] digits;
   } fcr_reply_type;

endpackage

>>> rtl/core/fcr_req_if.sv
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel that carries one received byte per transaction.
// ----------------------------------------------------------------------------
interface fcr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/fcr_rsp_if.sv
// ----------------------------------------------------------------------------
// Reply byte channel
// Valid/ready channel that carries one reply byte per transaction, with the
// last-byte flag and the currently shown digits.
// ----------------------------------------------------------------------------
interface fcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  tx_byte;
   logic        reply_last;
   logic [31:0] shown_digits;

   modport source (output valid, output tx_byte, output reply_last,
                   output shown_digits, input ready);
   modport sink   (input valid, input tx_byte, input reply_last,
                   input shown_digits, output ready);
endinterface

>>> rtl/core/fcr_frame_rx.sv
// ----------------------------------------------------------------------------
// Frame receiver
// Hunts for the head byte, collects the frame into the frame store, then in
// the cycle after the frame ends checks it, updates the digits and hands a
// reply record to the transmitter when the frame is for this station.
// ----------------------------------------------------------------------------
module fcr_frame_rx
   import fcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   fcr_req_if.sink       req,
   input  logic          csr_write_enable,
   input  logic [7:0]    csr_write_data,
   input  logic          tx_busy,
   output logic          reply_load,
   output fcr_reply_type reply
);

   localparam logic [1:0] PHASE_HUNT   = 2'd0;
   localparam logic [1:0] PHASE_HEADER = 2'd1;
   localparam logic [1:0] PHASE_BODY   = 2'd2;

   logic [7:0] own_address_ff;
   logic [1:0] phase_ff, phase_in;
   logic [8:0] remaining_ff, remaining_in;
   logic [4:0] position_ff, position_in;
   logic       done_ff, done_in;
   logic [31:0] digits_ff, digits_in;
   logic [7:0] frame_store_ff [FRAME_BYTES];

   logic       accept;
   logic       store_we;
   logic [4:0] store_pos;
   logic [8:0] remaining_dec;
   logic [7:0] frame_sum;
   logic [1:0] status;
   logic       address_match;

   // Station address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= 8'd1;
      end else if (csr_write_enable) begin
         own_address_ff <= csr_write_data;
      end
   end

   // The only byte that can stall is the last one of a frame, and only while
   // the previous reply still occupies the transmitter.
   assign req.ready = !((phase_ff == PHASE_BODY) && (remaining_ff == 9'd1)
                        && (done_ff || tx_busy));
   assign accept    = req.valid && req.ready;
   assign remaining_dec = remaining_ff - 9'd1;

   // Receive sequencing for one accepted byte.
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      position_in  = position_ff;
      done_in      = 1'b0;
      store_we     = 1'b0;
      store_pos    = position_ff;
      if (accept) begin
         case (phase_ff)
            PHASE_HEADER: begin
               store_we     = 1'b1;
               remaining_in = remaining_dec;
               if (remaining_dec == 9'd0) begin
                  phase_in     = PHASE_BODY;
                  remaining_in = {1'b0, req.rx_byte} + 9'd2;
               end
            end
            PHASE_BODY: begin
               store_we     = 1'b1;
               remaining_in = remaining_dec;
               if (remaining_dec == 9'd0) begin
                  phase_in = PHASE_HUNT;
                  done_in  = 1'b1;
               end
            end
            default: begin
               phase_in = PHASE_HUNT;
               if (req.rx_byte == HEAD_BYTE) begin
                  store_we     = 1'b1;
                  store_pos    = 5'd0;
                  phase_in     = PHASE_HEADER;
                  remaining_in = 9'd3;
               end
            end
         endcase
         if (store_we && (store_pos < POS_MAX)) begin
            position_in = store_pos + 5'd1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HUNT;
         remaining_ff <= 9'd0;
         position_ff  <= 5'd0;
         done_ff      <= 1'b0;
         digits_ff    <= 32'd0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         done_ff      <= done_in;
         digits_ff    <= digits_in;
      end
   end

   // Frame store; positions past the store are counted but dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_store_ff[i] <= 8'd0;
         end
      end else if (store_we && (store_pos < 5'(FRAME_BYTES))) begin
         frame_store_ff[store_pos[FRAME_IDX_W-1:0]] <= req.rx_byte;
      end
   end

   // Frame check, done from the stored frame in the cycle after it ends.
   assign frame_sum = frame_store_ff[1] + frame_store_ff[2] + frame_store_ff[3]
                    + frame_store_ff[4] + frame_store_ff[5] + frame_store_ff[6]
                    + frame_store_ff[7];
   assign address_match = (frame_store_ff[1] == own_address_ff);

   always_comb begin
      if (frame_sum != frame_store_ff[8]) begin
         status = STATUS_BAD_SUM;
      end else if (frame_store_ff[9] != TAIL_BYTE) begin
         status = STATUS_BAD_TAIL;
      end else begin
         status = STATUS_OK;
      end
   end

   // Digits take the payload bytes of a good frame for this station.
   always_comb begin
      digits_in = digits_ff;
      if (done_ff && address_match && (status == STATUS_OK)) begin
         digits_in = {frame_store_ff[4], frame_store_ff[5],
                      frame_store_ff[6], frame_store_ff[7]};
      end
   end

   assign reply_load     = done_ff && address_match;
   assign reply.address  = own_address_ff;
   assign reply.command  = frame_store_ff[2];
   assign reply.status   = status;
   assign reply.digits   = digits_in;

   // Frames are at least six bytes long, so completions never come back to back.
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("frame completion flagged in two consecutive cycles");

   // While hunting, no byte count may be left over.
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == PHASE_HUNT) |-> (remaining_ff == 9'd0))
      else $error("byte count left over while hunting for head");

   // A stall can only hold the closing byte of a frame.
   assert property (@(posedge clock) disable iff (reset)
                    !req.ready |-> (phase_ff == PHASE_BODY && remaining_ff == 9'd1))
      else $error("receive channel stalled outside a frame end");

endmodule

>>> rtl/core/fcr_reply_tx.sv
// ----------------------------------------------------------------------------
// Reply transmitter
// Holds one reply record and sends its seven bytes on the reply channel.
// ----------------------------------------------------------------------------
module fcr_reply_tx
   import fcr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          reply_load,
   input  fcr_reply_type reply,
   fcr_rsp_if.source     rsp,
   output logic          tx_busy
);

   logic          busy_ff;
   logic [2:0]    index_ff;
   fcr_reply_type record_ff;
   logic [7:0]    checksum_ff;
   logic          take;

   assign take    = rsp.valid && rsp.ready;
   assign tx_busy = busy_ff;

   // Sequencing of the seven reply bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= 3'd0;
      end else if (reply_load) begin
         busy_ff  <= 1'b1;
         index_ff <= 3'd0;
      end else if (take) begin
         if (index_ff == REPLY_LAST_IDX) begin
            busy_ff  <= 1'b0;
            index_ff <= 3'd0;
         end else begin
            index_ff <= index_ff + 3'd1;
         end
      end
   end

   // Reply record and its checksum over bytes one to four.
   always_ff @(posedge clock) begin
      if (reply_load) begin
         record_ff   <= reply;
         checksum_ff <= reply.address + reply.command + REPLY_KIND
                      + {6'd0, reply.status};
      end
   end

   // Byte selection for the current position.
   always_comb begin
      case (index_ff)
         3'd0:    rsp.tx_byte = HEAD_BYTE;
         3'd1:    rsp.tx_byte = record_ff.address;
         3'd2:    rsp.tx_byte = record_ff.command;
         3'd3:    rsp.tx_byte = REPLY_KIND;
         3'd4:    rsp.tx_byte = {6'd0, record_ff.status};
         3'd5:    rsp.tx_byte = checksum_ff;
         default: rsp.tx_byte = TAIL_BYTE;
      endcase
   end

   assign rsp.valid        = busy_ff;
   assign rsp.reply_last   = (index_ff == REPLY_LAST_IDX);
   assign rsp.shown_digits = record_ff.digits;

   // A new reply must never overwrite one still being sent.
   assert property (@(posedge clock) disable iff (reset) !(reply_load && busy_ff))
      else $error("reply record loaded while transmitter busy");

   // Taking the last byte frees the transmitter.
   assert property (@(posedge clock) disable iff (reset)
                    (take && rsp.reply_last) |=> !busy_ff)
      else $error("transmitter still busy after last reply byte");

   // A byte position past the head only exists inside a reply.
   assert property (@(posedge clock) disable iff (reset)
                    (index_ff != 3'd0) |-> busy_ff)
      else $error("reply byte position advanced while idle");

endmodule

>>> rtl/core/framed_command_receiver_with_reply_unit.sv
// ----------------------------------------------------------------------------
// Framed command receiver with reply
// Receives framed commands byte by byte, checks them and answers frames for
// this station with a seven-byte status reply.
//
//   Channel   Direction  Payload                                   Handshake
//   req_chan  in         rx_byte[7:0]                              valid/ready
//   rsp_chan  out        tx_byte[7:0], reply_last, shown_digits    valid/ready
//   csr_*     in         csr_write_data[7:0] (own address)         write enable
//
// Bytes may arrive in every cycle. A frame's check runs in the cycle after
// its last byte, and its reply bytes follow one per cycle from the
// transmitter register while the reply side is ready. The closing byte of
// a frame is held off only while the previous reply is still being sent.
// Reset is synchronous: own address to 1, all else but the held reply cleared.
// ----------------------------------------------------------------------------
module framed_command_receiver_with_reply_unit
   import fcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fcr_req_if.sink    req_chan,
   fcr_rsp_if.source  rsp_chan,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic          reply_load;
   logic          tx_busy;
   fcr_reply_type reply;

   // Frame collection and checking.
   fcr_frame_rx u_frame_rx (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .tx_busy          (tx_busy),
      .reply_load       (reply_load),
      .reply            (reply)
   );

   // Reply byte output.
   fcr_reply_tx u_reply_tx (
      .clock      (clock),
      .reset      (reset),
      .reply_load (reply_load),
      .reply      (reply),
      .rsp        (rsp_chan),
      .tx_busy    (tx_busy)
   );

endmodule

>>> test/framed_command_receiver_with_reply_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed command receiver testbench
// Feeds framed commands, noise and broken frames into the receiver byte by
// byte, predicts the seven-byte replies and the shown digits, and checks
// every reply transaction in order. Both channels idle at random, and the
// reply side holds off once for a long stretch to back up the receiver.
// ----------------------------------------------------------------------------
module framed_command_receiver_with_reply_unit_test;
   import fcr_pkg::*;

   // Kinds of frame that the stimulus builds.
   typedef enum logic [1:0] {
      FRAME_GOOD,
      FRAME_BAD_TAIL,
      FRAME_BAD_SUM,
      FRAME_BAD_BOTH
   } frame_kind_type;

   // Receiver phases as seen by the predictor.
   typedef enum logic [1:0] {
      RX_HUNT,
      RX_HEADER,
      RX_BODY
   } rx_state_type;

   // One expected reply transaction.
   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        reply_last;
      logic [31:0] shown_digits;
   } reply_beat_type;

   localparam int STALL_LIMIT   = 1000;
   localparam int PRESSURE_HOLD = 150;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   fcr_req_if req_chan ();
   fcr_rsp_if rsp_chan ();

   framed_command_receiver_with_reply_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state: a copy of the receiver and its station address.
   logic [7:0]   station_address = 8'd1;
   rx_state_type rx_state = RX_HUNT;
   logic [8:0]   bytes_left = '0;
   logic [4:0]   write_pos = '0;
   logic [7:0]   frame_copy [FRAME_BYTES] = '{default: 8'h00};
   logic [31:0]  digits_shown = '0;

   reply_beat_type reply_beats_due [$];
   logic [7:0]     bytes_to_send [$];

   int bytes_offered = 0;
   int bytes_accepted = 0;
   int idle_cycles = 0;
   int failures = 0;
   int send_gap = 0;
   int hold_left = 0;
   bit send_calm = 1'b0;
   bit drain_calm = 1'b1;
   bit pressure_done = 1'b0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Keep one received byte in the frame copy, as the receiver does.
   task automatic keep_rx_byte(input logic [7:0] data);
      if (write_pos < FRAME_BYTES)
         frame_copy[write_pos] = data;
      if (write_pos < POS_MAX)
         write_pos = write_pos + 5'd1;
   endtask

   // Advance the receiver copy by one byte and queue any reply it causes.
   task automatic predict_rx_byte(input logic [7:0] data);
      logic [7:0]     check_sum;
      logic [1:0]     status;
      logic [7:0]     reply [7];
      reply_beat_type beat;
      int             i;
      case (rx_state)
         RX_HEADER: begin
            keep_rx_byte(data);
            bytes_left = bytes_left - 9'd1;
            if (bytes_left == 0) begin
               rx_state = RX_BODY;
               bytes_left = {1'b0, data} + 9'd2;
            end
         end
         RX_BODY: begin
            keep_rx_byte(data);
            bytes_left = bytes_left - 9'd1;
            // Frame complete: only frames for this station are answered.
            if (bytes_left == 0) begin
               rx_state = RX_HUNT;
               if (frame_copy[1] == station_address) begin
                  status = STATUS_OK;
                  if (frame_copy[9] != TAIL_BYTE)
                     status = STATUS_BAD_TAIL;
                  check_sum = '0;
                  for (i = 1; i < 8; i++)
                     check_sum = check_sum + frame_copy[i];
                  // A checksum failure outranks a bad tail.
                  if (check_sum != frame_copy[8])
                     status = STATUS_BAD_SUM;
                  if (status == STATUS_OK)
                     digits_shown = {frame_copy[4], frame_copy[5],
                                     frame_copy[6], frame_copy[7]};
                  reply[0] = HEAD_BYTE;
                  reply[1] = station_address;
                  reply[2] = frame_copy[2];
                  reply[3] = REPLY_KIND;
                  reply[4] = {6'd0, status};
                  reply[5] = reply[1] + reply[2] + reply[3] + reply[4];
                  reply[6] = TAIL_BYTE;
                  for (i = 0; i < 7; i++) begin
                     beat.tx_byte = reply[i];
                     beat.reply_last = (i == 6);
                     beat.shown_digits = digits_shown;
                     reply_beats_due.push_back(beat);
                  end
               end
            end
         end
         default: begin
            rx_state = RX_HUNT;
            if (data == HEAD_BYTE) begin
               write_pos = '0;
               keep_rx_byte(data);
               rx_state = RX_HEADER;
               bytes_left = 9'd3;
            end
         end
      endcase
   endtask

   // Build one frame with length byte len and queue its bytes for sending.
   // A cut frame stops early and leaves the receiver in the middle of it.
   task automatic queue_frame(input frame_kind_type kind, input logic [7:0] addr,
                              input logic [7:0] cmd, input int len,
                              input logic [31:0] payload, input bit cut);
      logic [7:0] frame [$];
      logic [7:0] check_sum;
      int         i;
      int         keep;
      frame = {HEAD_BYTE, addr, cmd, 8'(len)};
      for (i = 4; i < len + 6; i++)
         frame.push_back((i < 8) ? payload[31 - 8 * (i - 4) -: 8] : 8'($urandom));
      if (len >= 3) begin
         check_sum = '0;
         for (i = 1; i < 8; i++)
            check_sum = check_sum + frame[i];
         if (kind == FRAME_BAD_SUM || kind == FRAME_BAD_BOTH)
            check_sum = check_sum + 8'($urandom_range(1, 255));
         frame[8] = check_sum;
      end
      if (len >= 4) begin
         frame[9] = TAIL_BYTE;
         if (kind == FRAME_BAD_TAIL || kind == FRAME_BAD_BOTH)
            frame[9] = TAIL_BYTE ^ 8'($urandom_range(1, 255));
      end
      keep = cut ? $urandom_range(1, frame.size() - 1) : frame.size();
      for (i = 0; i < keep; i++)
         bytes_to_send.push_back(frame[i]);
   endtask

   // Queue random frames, noise and broken frames worth about count bytes.
   task automatic queue_random_frames(input int count);
      int         goal;
      int         r;
      int         n;
      logic [7:0] noise;
      goal = bytes_to_send.size() + count;
      while (bytes_to_send.size() < goal) begin
         // A little line noise between frames, now and then a stray head.
         n = $urandom_range(0, 2);
         repeat (n) begin
            noise = 8'($urandom);
            if (noise == HEAD_BYTE && $urandom_range(3) != 0)
               noise = ~noise;
            bytes_to_send.push_back(noise);
         end
         r = $urandom_range(99);
         if (r < 40)
            queue_frame(FRAME_GOOD, station_address, 8'($urandom), 4, $urandom, 1'b0);
         else if (r < 50)
            queue_frame(FRAME_BAD_TAIL, station_address, 8'($urandom), 4, $urandom, 1'b0);
         else if (r < 60)
            queue_frame(FRAME_BAD_SUM, station_address, 8'($urandom), 4, $urandom, 1'b0);
         else if (r < 65)
            queue_frame(FRAME_BAD_BOTH, station_address, 8'($urandom), 4, $urandom, 1'b0);
         else if (r < 77)
            queue_frame(FRAME_GOOD, station_address ^ 8'($urandom_range(1, 255)),
                        8'($urandom), 4, $urandom, 1'b0);
         else if (r < 87)
            queue_frame(FRAME_GOOD, station_address, 8'($urandom),
                        $urandom_range(0, 3), $urandom, 1'b0);
         else if (r < 95)
            queue_frame(FRAME_GOOD, station_address, 8'($urandom),
                        $urandom_range(5, 12), $urandom, 1'b0);
         else
            queue_frame(FRAME_GOOD, station_address, 8'($urandom), 4, $urandom, 1'b1);
      end
   endtask

   // Wait until every queued byte is taken and every reply has arrived.
   task automatic wait_for_idle();
      while (bytes_to_send.size() != 0 || bytes_accepted != bytes_offered ||
             reply_beats_due.size() != 0)
         @(posedge clock);
   endtask

   // Change the station address while the block is idle.
   task automatic set_station_address(input logic [7:0] value);
      wait_for_idle();
      repeat (16) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      station_address = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Byte driver: offers queued bytes with random gaps between transactions.
   always @(negedge clock) begin : rx_driver
      logic offer;
      int   r;
      if (!reset) begin
         offer = req_chan.valid;
         if (offer && bytes_accepted == bytes_offered) begin
            offer = 1'b0;
            if ($urandom_range(39) == 0)
               send_calm = !send_calm;
            r = $urandom_range(99);
            if (send_calm || r < 70)
               send_gap = 0;
            else if (r < 95)
               send_gap = $urandom_range(1, 3);
            else
               send_gap = $urandom_range(15, 40);
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (bytes_to_send.size() > 0) begin
               req_chan.rx_byte <= bytes_to_send.pop_front();
               bytes_offered++;
               offer = 1'b1;
            end
         end
         req_chan.valid <= offer;
      end
   end

   // Reply sink: random stalls, calm stretches, and one long hold-off that
   // starts on the first reply seen while ten or more bytes are still queued.
   always @(negedge clock) begin : reply_drain
      int r;
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!pressure_done && rsp_chan.valid &&
                      bytes_to_send.size() >= 10) begin
            pressure_done = 1'b1;
            hold_left = PRESSURE_HOLD;
            rsp_chan.ready <= 1'b0;
         end else begin
            if ($urandom_range(49) == 0)
               drain_calm = !drain_calm;
            r = $urandom_range(99);
            if (drain_calm || r < 70) begin
               rsp_chan.ready <= 1'b1;
            end else if (r < 95) begin
               hold_left = $urandom_range(0, 3);
               rsp_chan.ready <= 1'b0;
            end else begin
               hold_left = $urandom_range(10, 30);
               rsp_chan.ready <= 1'b0;
            end
         end
      end
   end

   // Monitor: predicts on each byte taken and checks each reply transaction.
   always @(posedge clock) begin : monitor
      reply_beat_type due;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predict_rx_byte(req_chan.rx_byte);
            bytes_accepted <= bytes_accepted + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (reply_beats_due.size() == 0) begin
               $error("unexpected reply transaction: tx_byte %02h", rsp_chan.tx_byte);
               failures++;
            end else begin
               due = reply_beats_due.pop_front();
               if (rsp_chan.tx_byte !== due.tx_byte) begin
                  $error("tx_byte: expected %02h, actual %02h",
                         due.tx_byte, rsp_chan.tx_byte);
                  failures++;
               end
               if (rsp_chan.reply_last !== due.reply_last) begin
                  $error("reply_last: expected %0b, actual %0b",
                         due.reply_last, rsp_chan.reply_last);
                  failures++;
               end
               if (rsp_chan.shown_digits !== due.shown_digits) begin
                  $error("shown_digits: expected %08h, actual %08h",
                         due.shown_digits, rsp_chan.shown_digits);
                  failures++;
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // Stimulus sequence and final verdict.
   initial begin : stimulus
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening at the reset address: noise, a good frame with
      // extreme digits, a frame with both tail and checksum wrong, and a
      // zero-length frame that reuses stale bytes of the frame before it.
      bytes_to_send.push_back(8'h00);
      bytes_to_send.push_back(8'hFF);
      queue_frame(FRAME_GOOD, station_address, 8'h00, 4, 32'hFF00_5AA5, 1'b0);
      queue_frame(FRAME_BAD_BOTH, station_address, 8'hFF, 4, 32'h0123_4567, 1'b0);
      queue_frame(FRAME_GOOD, station_address, 8'h5C, 0, 32'h0000_0000, 1'b0);

      // Lowest address: a foreign frame first, then random traffic.
      set_station_address(8'h00);
      queue_frame(FRAME_GOOD, 8'h01, 8'($urandom), 4, $urandom, 1'b0);
      queue_random_frames(16);

      // Highest address: a bad tail alone and a long frame, then random.
      set_station_address(8'hFF);
      queue_frame(FRAME_BAD_TAIL, station_address, 8'($urandom), 4, $urandom, 1'b0);
      queue_frame(FRAME_GOOD, station_address, 8'($urandom), 12, $urandom, 1'b0);
      queue_random_frames(14);

      // Random address.
      set_station_address(8'($urandom));
      queue_random_frames(14);

      wait_for_idle();
      repeat (20) @(posedge clock);
      if (failures == 0 && reply_beats_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/fcr_pkg.sv
rtl/core/fcr_req_if.sv
rtl/core/fcr_rsp_if.sv
rtl/core/fcr_frame_rx.sv
rtl/core/fcr_reply_tx.sv
rtl/core/framed_command_receiver_with_reply_unit.sv
test/framed_command_receiver_with_reply_unit_test.sv
